>>> rtl/utu_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder package
// Holds the result kinds, the result record and the encoding constants that
// the decoder modules use.
// ----------------------------------------------------------------------------
package utu_pkg;

  // Result queue geometry. The depth must be a power of two so that the
  // pointers wrap naturally.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Kind of each result transaction.
  typedef enum logic [1:0] {
    KIND_UNIT  = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_END   = 2'd2
  } result_kind_t;

  // One result as it travels from the decoder to the result queue.
  typedef struct packed {
    result_kind_t kind;
    logic [15:0]  unit;
    logic         last;
  } result_t;

  // Lead byte masks and tags.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  // Code point limits.
  localparam logic [20:0] MIN_CP_LEN1    = 21'h000080;
  localparam logic [20:0] MIN_CP_LEN2    = 21'h000800;
  localparam logic [20:0] SUPP_BASE      = 21'h010000;
  localparam logic [20:0] MAX_CP         = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST     = 21'h00D800;
  localparam logic [20:0] SURR_LAST      = 21'h00DFFF;
  localparam logic [20:0] BMP_LAST       = 21'h00FFFF;
  localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;

endpackage

>>> rtl/utf8_to_utf16_decoder_unit.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder unit
// Top level: input register, decode step and result queue.
// ----------------------------------------------------------------------------
// The unit takes one UTF-8 byte per input transaction and can accept a byte
// in every cycle while the result queue has room for the decode step. Each
// byte is first captured in an input register, decoded there once the queue
// can take its results and written into a four-entry result queue, from which
// the first result is presented at the result port. A byte
// normally gives one result (or none for a lead or middle continuation
// byte); a supplementary code point gives a high and a low surrogate, which
// leave one after the other, as the result port delivers one result per
// cycle while out_ready is high. The decode step advances only while the
// queue has two free slots, which sets the throughput when results stall.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [15:0] out_code_unit,
  output logic        out_last_of_item
);

  logic             hold_valid_r;
  logic [7:0]       hold_byte_r;
  logic             dec_step;
  logic             room;
  logic [1:0]       res_count;
  logic [1:0]       push_count;
  utu_pkg::result_t res_first;
  utu_pkg::result_t res_second;
  utu_pkg::result_t out_entry;

  // The held byte is decoded whenever the queue can take its results.
  assign dec_step   = hold_valid_r && room;
  assign in_ready   = !hold_valid_r || dec_step;
  assign push_count = dec_step ? res_count : 2'd0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte_r <= in_data_byte;
    end
  end

  utu_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (dec_step),
    .data_byte  (hold_byte_r),
    .res_count  (res_count),
    .res_first  (res_first),
    .res_second (res_second)
  );

  utu_result_fifo u_result_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_count  (push_count),
    .push_first  (res_first),
    .push_second (res_second),
    .pop         (out_valid && out_ready),
    .room        (room),
    .out_valid   (out_valid),
    .out_entry   (out_entry)
  );

  // Result channel payload.
  assign out_result_kind  = out_entry.kind;
  assign out_code_unit    = out_entry.unit;
  assign out_last_of_item = out_entry.last;

endmodule

>>> rtl/utu_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Holds the partial code point and sequence counters, and turns one byte into
// zero, one or two results combinationally.
// ----------------------------------------------------------------------------
module utu_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  output logic [1:0]       res_count,
  output utu_pkg::result_t res_first,
  output utu_pkg::result_t res_second
);

  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  remaining_r, remaining_nxt;
  logic [1:0]  seq_len_r, seq_len_nxt;

  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [1:0]  rem_dec;
  logic        bad;

  // Candidate code point once this byte is appended, and its checks.
  assign cp      = {partial_r[14:0], data_byte[5:0]};
  assign cp_off  = cp - utu_pkg::SUPP_BASE;
  assign rem_dec = remaining_r - 2'd1;
  assign bad     = ((seq_len_r == 2'd1) && (cp < utu_pkg::MIN_CP_LEN1)) ||
                   ((seq_len_r == 2'd2) && (cp < utu_pkg::MIN_CP_LEN2)) ||
                   ((seq_len_r == 2'd3) && (cp < utu_pkg::SUPP_BASE))   ||
                   (cp > utu_pkg::MAX_CP) ||
                   ((cp >= utu_pkg::SURR_FIRST) && (cp <= utu_pkg::SURR_LAST));

  // Next state and results for the byte in hand.
  always_comb begin
    partial_nxt   = partial_r;
    remaining_nxt = remaining_r;
    seq_len_nxt   = seq_len_r;
    res_count     = 2'd0;
    res_first     = '{kind: utu_pkg::KIND_UNIT, unit: 16'h0000, last: 1'b1};
    res_second    = '{kind: utu_pkg::KIND_UNIT, unit: 16'h0000, last: 1'b1};

    if (remaining_r == 2'd0) begin
      priority if (data_byte == 8'h00) begin
        res_count      = 2'd1;
        res_first.kind = utu_pkg::KIND_END;
      end else if (!data_byte[7]) begin
        res_count      = 2'd1;
        res_first.unit = {8'h00, data_byte};
      end else if ((data_byte & utu_pkg::LEAD2_MASK) == utu_pkg::LEAD2_TAG) begin
        partial_nxt   = {16'h0000, data_byte[4:0]};
        seq_len_nxt   = 2'd1;
        remaining_nxt = 2'd1;
      end else if ((data_byte & utu_pkg::LEAD3_MASK) == utu_pkg::LEAD3_TAG) begin
        partial_nxt   = {17'h00000, data_byte[3:0]};
        seq_len_nxt   = 2'd2;
        remaining_nxt = 2'd2;
      end else if ((data_byte & utu_pkg::LEAD4_MASK) == utu_pkg::LEAD4_TAG) begin
        partial_nxt   = {18'h00000, data_byte[2:0]};
        seq_len_nxt   = 2'd3;
        remaining_nxt = 2'd3;
      end else begin
        res_count      = 2'd1;
        res_first.kind = utu_pkg::KIND_ERROR;
        partial_nxt    = '0;
        seq_len_nxt    = 2'd0;
      end
    end else if (data_byte[7:6] != utu_pkg::CONT_TAG) begin
      // Sequence broken: drop the byte and go idle.
      res_count      = 2'd1;
      res_first.kind = utu_pkg::KIND_ERROR;
      partial_nxt    = '0;
      remaining_nxt  = 2'd0;
      seq_len_nxt    = 2'd0;
    end else if (rem_dec != 2'd0) begin
      partial_nxt   = cp;
      remaining_nxt = rem_dec;
    end else begin
      // Sequence complete: check it and emit one or two code units.
      partial_nxt   = '0;
      remaining_nxt = 2'd0;
      seq_len_nxt   = 2'd0;
      priority if (bad) begin
        res_count      = 2'd1;
        res_first.kind = utu_pkg::KIND_ERROR;
      end else if (cp <= utu_pkg::BMP_LAST) begin
        res_count      = 2'd1;
        res_first.unit = cp[15:0];
      end else begin
        res_count       = 2'd2;
        res_first.unit  = utu_pkg::SURR_HIGH_BASE | {6'b000000, cp_off[19:10]};
        res_first.last  = 1'b0;
        res_second.unit = utu_pkg::SURR_LOW_BASE | {6'b000000, cp_off[9:0]};
      end
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r   <= '0;
      remaining_r <= 2'd0;
      seq_len_r   <= 2'd0;
    end else if (step) begin
      partial_r   <= partial_nxt;
      remaining_r <= remaining_nxt;
      seq_len_r   <= seq_len_nxt;
    end
  end

endmodule

>>> rtl/utu_result_fifo.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 result queue
// A small register queue that takes up to two results a cycle from the
// decoder and hands one result a cycle to the result channel while it is ready.
// ----------------------------------------------------------------------------
module utu_result_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_count,
  input  utu_pkg::result_t push_first,
  input  utu_pkg::result_t push_second,
  input  logic             pop,
  output logic             room,
  output logic             out_valid,
  output utu_pkg::result_t out_entry
);

  utu_pkg::result_t entries [utu_pkg::RES_DEPTH];

  logic [utu_pkg::RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [utu_pkg::RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [utu_pkg::RES_CNT_W-1:0] count_r, count_nxt;
  logic [utu_pkg::RES_PTR_W-1:0] wr_ptr_second;

  // The decoder may step only when two slots are free.
  assign room          = count_r <= utu_pkg::RES_CNT_W'(utu_pkg::RES_DEPTH - 2);
  assign out_valid     = count_r != '0;
  assign out_entry     = entries[rd_ptr_r];
  assign wr_ptr_second = wr_ptr_r + utu_pkg::RES_PTR_W'(1);

  // Pointer and fill level updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + utu_pkg::RES_PTR_W'(push_count);
    rd_ptr_nxt = rd_ptr_r + utu_pkg::RES_PTR_W'(pop);
    count_nxt  = count_r + utu_pkg::RES_CNT_W'(push_count) - utu_pkg::RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr_r] <= push_first;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_second] <= push_second;
    end
  end

endmodule

>>> rtl/utu_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder port checker
// Watches the top-level ports for result channel consistency.
// ----------------------------------------------------------------------------
module utu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [15:0] out_code_unit,
  input logic        out_last_of_item
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
    $stable(out_code_unit) && $stable(out_last_of_item))
    else $error("result payload changed while stalled");

  // Only the three defined kinds are ever presented.
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == utu_pkg::KIND_UNIT) ||
    (out_result_kind == utu_pkg::KIND_ERROR) || (out_result_kind == utu_pkg::KIND_END))
    else $error("undefined result kind");

  // Error and end results carry a zero unit and close their byte.
  a_non_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != utu_pkg::KIND_UNIT) |->
    (out_code_unit == 16'h0000) && out_last_of_item)
    else $error("error or end result malformed");

  // A result that is not the last of its byte is always a high surrogate.
  a_high_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_item |->
    (out_result_kind == utu_pkg::KIND_UNIT) && (out_code_unit[15:10] == 6'b110110))
    else $error("non-final result is not a high surrogate");

  // A high surrogate, once taken, is followed by a low surrogate.
  a_low_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_item ##1 out_valid |->
    (out_result_kind == utu_pkg::KIND_UNIT) && (out_code_unit[15:10] == 6'b110111) &&
    out_last_of_item)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_decoder_unit utu_checker u_utu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_kind  (out_result_kind),
  .out_code_unit    (out_code_unit),
  .out_last_of_item (out_last_of_item)
);
